// ----- sv/assert_macros.svh -----
// Assertion macros shared by the decoder's RTL files.
// The checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTFD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define RTFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RTFD_ASSERT(lbl, clk, rst, prop)
`define RTFD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RTFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- sv/rtfd_pkg.sv -----
// ----------------------------------------------------------------------------
// Radar target frame decoder package
// Frame layout constants, target record types and fixed-point constants.
// ----------------------------------------------------------------------------
package rtfd_pkg;

   localparam logic [7:0] HDR_BYTE0 = 8'hAA;
   localparam logic [7:0] HDR_BYTE1 = 8'hFF;
   localparam logic [7:0] HDR_BYTE2 = 8'h03;
   localparam logic [7:0] HDR_BYTE3 = 8'h00;
   localparam logic [7:0] TAIL_BYTE0 = 8'h55;
   localparam logic [7:0] TAIL_BYTE1 = 8'hCC;

   localparam int FRAME_BYTES = 26;
   localparam int DATA_BYTES = 24;
   localparam int NUM_TARGETS = 3;
   localparam int SERIES_TERMS = 20;

   // Angles are radians in Q30.
   localparam logic signed [35:0] Q30_HALF_PI = 36'sh0_6487_ED51;
   localparam logic signed [35:0] Q30_QUARTER_PI = 36'sh0_3243_F6A9;
   localparam logic signed [35:0] Q30_HALF_MINUS_QUARTER = 36'sh0_3243_F6A8;
   localparam logic signed [35:0] Q30_HALF_PLUS_PI = 36'sh1_2D97_C7F3;
   localparam logic [48:0] Q30_PI_U = 49'h0_C90F_DAA2;
   localparam logic [47:0] Q30_TWO_PI_U = 48'h1_921F_B544;
   localparam logic [15:0] CENTIDEG_SCALE = 16'd36000;
   localparam logic [63:0] RECIP_NUM = 64'h1_0000_0000;
   // floor(2^49 / 2pi in Q30), used to estimate the degree quotient.
   localparam logic [16:0] DEG_RECIP = 17'((64'd1 << 49) / 64'h1_921F_B544);

   typedef struct packed {
      logic [15:0] p_raw;
      logic [15:0] v_raw;
      logic [15:0] y_raw;
      logic [15:0] x_raw;
   } rtfd_target_type;

   typedef struct packed {
      rtfd_target_type [NUM_TARGETS-1:0] tgt;
   } rtfd_frame_type;

   // floor(2^32 / (2k+1)) for the atan series terms; term 0 needs no divide.
   function automatic logic [31:0] rtfd_recip(input logic [4:0] k);
      logic [63:0] m;
      case (k)
         5'd1: m = RECIP_NUM / 64'd3;
         5'd2: m = RECIP_NUM / 64'd5;
         5'd3: m = RECIP_NUM / 64'd7;
         5'd4: m = RECIP_NUM / 64'd9;
         5'd5: m = RECIP_NUM / 64'd11;
         5'd6: m = RECIP_NUM / 64'd13;
         5'd7: m = RECIP_NUM / 64'd15;
         5'd8: m = RECIP_NUM / 64'd17;
         5'd9: m = RECIP_NUM / 64'd19;
         5'd10: m = RECIP_NUM / 64'd21;
         5'd11: m = RECIP_NUM / 64'd23;
         5'd12: m = RECIP_NUM / 64'd25;
         5'd13: m = RECIP_NUM / 64'd27;
         5'd14: m = RECIP_NUM / 64'd29;
         5'd15: m = RECIP_NUM / 64'd31;
         5'd16: m = RECIP_NUM / 64'd33;
         5'd17: m = RECIP_NUM / 64'd35;
         5'd18: m = RECIP_NUM / 64'd37;
         5'd19: m = RECIP_NUM / 64'd39;
         default: m = 64'd0;
      endcase
      return m[31:0];
   endfunction

endpackage

// ----- sv/rtfd_req_if.sv -----
// ----------------------------------------------------------------------------
// Byte request channel
// Valid/ready stream that carries one received serial byte per transfer.
// ----------------------------------------------------------------------------
interface rtfd_req_if;
   logic valid;
   logic ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink (input valid, input byte_in, output ready);
endinterface

// ----- sv/rtfd_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Target response channel
// Valid/ready stream that carries one decoded target per transfer.
// ----------------------------------------------------------------------------
interface rtfd_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] target_slot;
   logic last;
   logic detected;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic signed [15:0] velocity;
   logic [15:0] range_mm;
   logic signed [15:0] bearing_centideg;

   modport source (output valid, output target_slot, output last, output detected,
                   output pos_x, output pos_y, output velocity, output range_mm,
                   output bearing_centideg, input ready);
   modport sink (input valid, input target_slot, input last, input detected,
                 input pos_x, input pos_y, input velocity, input range_mm,
                 input bearing_centideg, output ready);
endinterface

// ----- sv/rtfd_front.sv -----
// ----------------------------------------------------------------------------
// Frame hunter
// Finds the header, collects the payload and pushes good frames to the queue.
// ----------------------------------------------------------------------------
module rtfd_front (
   input  logic clock,
   input  logic reset,
   rtfd_req_if.sink req_chan,
   input  logic full,
   output logic push,
   output rtfd_pkg::rtfd_frame_type push_frame
);

   typedef enum logic [2:0] {PH_H0, PH_H1, PH_H2, PH_H3, PH_DATA} phase_type;

   phase_type phase_ff;
   logic [4:0] count_ff;
   logic [7:0] store_ff [rtfd_pkg::DATA_BYTES+1];
   logic accept;
   logic at_tail;

   assign at_tail = (phase_ff == PH_DATA) && (count_ff == 5'(rtfd_pkg::FRAME_BYTES - 1));
   // The last byte is only taken when a good frame would have room.
   assign req_chan.ready = !(at_tail && full);
   assign accept = req_chan.valid && req_chan.ready;
   assign push = accept && at_tail && (store_ff[rtfd_pkg::DATA_BYTES] == rtfd_pkg::TAIL_BYTE0)
                 && (req_chan.byte_in == rtfd_pkg::TAIL_BYTE1);

   always_comb begin
      for (int t = 0; t < rtfd_pkg::NUM_TARGETS; t++) begin
         push_frame.tgt[t].x_raw = {store_ff[8*t+1], store_ff[8*t]};
         push_frame.tgt[t].y_raw = {store_ff[8*t+3], store_ff[8*t+2]};
         push_frame.tgt[t].v_raw = {store_ff[8*t+5], store_ff[8*t+4]};
         push_frame.tgt[t].p_raw = {store_ff[8*t+7], store_ff[8*t+6]};
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_DATA) && !at_tail) begin
         store_ff[count_ff] <= req_chan.byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_H0;
         count_ff <= 5'd0;
      end else if (accept) begin
         case (phase_ff)
            PH_H0: phase_ff <= (req_chan.byte_in == rtfd_pkg::HDR_BYTE0) ? PH_H1 : PH_H0;
            PH_H1: phase_ff <= (req_chan.byte_in == rtfd_pkg::HDR_BYTE1) ? PH_H2 : PH_H0;
            PH_H2: phase_ff <= (req_chan.byte_in == rtfd_pkg::HDR_BYTE2) ? PH_H3 : PH_H0;
            PH_H3: begin
               count_ff <= 5'd0;
               phase_ff <= (req_chan.byte_in == rtfd_pkg::HDR_BYTE3) ? PH_DATA : PH_H0;
            end
            PH_DATA: begin
               if (at_tail) begin
                  count_ff <= 5'd0;
                  phase_ff <= PH_H0;
               end else begin
                  count_ff <= count_ff + 5'd1;
               end
            end
            default: phase_ff <= PH_H0;
         endcase
      end
   end

endmodule

// ----- sv/rtfd_queue.sv -----
// ----------------------------------------------------------------------------
// Frame queue
// Two-entry queue of good frames between the hunter and the target unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtfd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  rtfd_pkg::rtfd_frame_type push_frame,
   output logic full,
   output logic head_valid,
   output rtfd_pkg::rtfd_frame_type head_frame,
   input  logic pop
);

   rtfd_pkg::rtfd_frame_type data_ff [2];
   logic wr_ptr_ff;
   logic rd_ptr_ff;
   logic [1:0] count_ff;

   assign full = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_frame = data_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ptr_ff] <= push_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   `RTFD_ASSERT(a_count_range, clock, reset, count_ff != 2'd3)
   `RTFD_ASSERT_IMP(a_no_push_full, clock, reset, push, !full)
   `RTFD_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, head_valid)

endmodule

// ----- sv/rtfd_back.sv -----
// ----------------------------------------------------------------------------
// Target unit
// Decodes one target at a time: range by digit square root, bearing by a
// Q30 atan series, then conversion to hundredths of a degree.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtfd_back (
   input  logic clock,
   input  logic reset,
   input  logic head_valid,
   input  rtfd_pkg::rtfd_frame_type head_frame,
   output logic pop,
   rtfd_rsp_if.source rsp_chan
);

   typedef enum logic [3:0] {ST_IDLE, ST_SQ, ST_SUM, ST_DIV, ST_U2, ST_TA, ST_TB, ST_ANG1,
                             ST_ANG2, ST_ANG3, ST_M1, ST_M2, ST_DEG, ST_DQ, ST_DFIX,
                             ST_OUT} state_type;

   state_type state_ff;
   logic [1:0] slot_ff;
   logic [4:0] cnt_ff;
   logic signed [15:0] x_ff, y_ff, v_ff;
   logic det_ff, xneg_ff, yneg_ff, origin_ff, fold_ff, steep_ff;
   logic [14:0] ax_ff, ay_ff;
   logic [29:0] xsq_ff, ysq_ff;
   logic [30:0] s_ff;
   logic [31:0] res_ff, bit_ff;
   logic [15:0] den_ff;
   logic [16:0] rem_ff;
   logic [29:0] u_ff;
   logic [27:0] u2_ff;
   logic [28:0] p_ff, pnext_ff;
   logic [60:0] prod_ff;
   logic [4:0] k_ff;
   logic signed [31:0] acc_ff;
   logic signed [35:0] phi_ff, r_ff;
   logic [32:0] mag_ff;
   logic neg_ff;
   logic [48:0] n_ff;
   logic [41:0] rh_ff;
   logic [40:0] rl_ff;
   logic [14:0] qd_ff;

   logic out_valid_ff;
   logic [1:0] out_slot_ff;
   logic out_last_ff, out_det_ff;
   logic signed [15:0] out_x_ff, out_y_ff, out_v_ff, out_bear_ff;
   logic [15:0] out_range_ff;

   rtfd_pkg::rtfd_target_type tgt;
   logic out_free;
   logic [14:0] a_min, b_max;
   logic [16:0] rem2;
   logic div_ge;
   logic [31:0] trial;
   logic sq_ge;
   logic [5:0] dval;
   logic [28:0] q0;
   logic [34:0] qd_prod;
   logic [28:0] rfix;
   logic [29:0] term;
   logic [57:0] usq;
   logic [56:0] pu_prod;
   logic signed [35:0] acc_x;
   logic [32:0] lo_prod;
   logic [31:0] hi_prod;
   logic [65:0] recip_sum;
   logic [47:0] qd_mul;
   logic [48:0] deg_rem;
   logic deg_ge;
   logic [15:0] bear_mag;

   assign tgt = head_frame.tgt[slot_ff];
   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop = (state_ff == ST_OUT) && out_free && (slot_ff == 2'd2);

   always_comb begin
      a_min = (ax_ff < ay_ff) ? ax_ff : ay_ff;
      b_max = (ax_ff < ay_ff) ? ay_ff : ax_ff;
      rem2 = {rem_ff[15:0], 1'b0};
      div_ge = (rem2 >= {1'b0, den_ff});
      trial = res_ff + bit_ff;
      sq_ge = ({1'b0, s_ff} >= trial);
      dval = {k_ff, 1'b1};
      q0 = prod_ff[60:32];
      qd_prod = q0 * dval;
      rfix = p_ff - qd_prod[28:0];
      if (k_ff == 5'd0) begin
         term = {1'b0, p_ff};
      end else if (rfix >= 29'(dval)) begin
         term = 30'(q0) + 30'd1;
      end else begin
         term = 30'(q0);
      end
      usq = u_ff[28:0] * u_ff[28:0];
      pu_prod = p_ff * u2_ff;
      acc_x = 36'(acc_ff);
      lo_prod = 33'(mag_ff[16:0]) * 33'(rtfd_pkg::CENTIDEG_SCALE);
      hi_prod = mag_ff[32:17] * rtfd_pkg::CENTIDEG_SCALE;
      recip_sum = {rh_ff, 24'd0} + 66'(rl_ff);
      qd_mul = 48'(qd_ff) * rtfd_pkg::Q30_TWO_PI_U;
      deg_rem = n_ff - 49'(qd_mul);
      deg_ge = (deg_rem >= {1'b0, rtfd_pkg::Q30_TWO_PI_U});
      bear_mag = {1'b0, qd_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         slot_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready && (state_ff != ST_OUT)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (head_valid) begin
                  x_ff <= tgt.x_raw[15] ? 16'(tgt.x_raw[14:0]) : -16'(tgt.x_raw[14:0]);
                  y_ff <= tgt.y_raw[15] ? 16'(tgt.y_raw[14:0]) : -16'(tgt.y_raw[14:0]);
                  v_ff <= tgt.v_raw[15] ? 16'(tgt.v_raw[14:0]) : -16'(tgt.v_raw[14:0]);
                  ax_ff <= tgt.x_raw[14:0];
                  ay_ff <= tgt.y_raw[14:0];
                  xneg_ff <= !tgt.x_raw[15] && (tgt.x_raw[14:0] != 15'd0);
                  yneg_ff <= !tgt.y_raw[15] && (tgt.y_raw[14:0] != 15'd0);
                  origin_ff <= (tgt.x_raw[14:0] == 15'd0) && (tgt.y_raw[14:0] == 15'd0);
                  det_ff <= |tgt;
                  state_ff <= ST_SQ;
               end
            end
            ST_SQ: begin
               xsq_ff <= ax_ff * ax_ff;
               ysq_ff <= ay_ff * ay_ff;
               steep_ff <= (ay_ff > ax_ff);
               // Ratios above 0.4 are folded around pi/4 to keep the series short.
               if ((18'({a_min, 2'b00}) + 18'(a_min)) > 18'({b_max, 1'b0})) begin
                  fold_ff <= 1'b1;
                  den_ff <= 16'(a_min) + 16'(b_max);
                  rem_ff <= 17'(b_max - a_min);
               end else begin
                  fold_ff <= 1'b0;
                  den_ff <= 16'(b_max);
                  rem_ff <= 17'(a_min);
               end
               res_ff <= 32'd0;
               bit_ff <= 32'h4000_0000;
               u_ff <= 30'd0;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               s_ff <= 31'(xsq_ff) + 31'(ysq_ff);
               cnt_ff <= 5'd0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               // One quotient bit per cycle; the 16-bit square root runs alongside.
               rem_ff <= div_ge ? (rem2 - {1'b0, den_ff}) : rem2;
               u_ff <= {u_ff[28:0], div_ge};
               if (cnt_ff < 5'd16) begin
                  if (sq_ge) begin
                     s_ff <= s_ff - trial[30:0];
                     res_ff <= (res_ff >> 1) + bit_ff;
                  end else begin
                     res_ff <= res_ff >> 1;
                  end
                  bit_ff <= bit_ff >> 2;
               end
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd29) begin
                  state_ff <= ST_U2;
               end
            end
            ST_U2: begin
               u2_ff <= usq[57:30];
               p_ff <= u_ff[28:0];
               acc_ff <= 32'sd0;
               k_ff <= 5'd0;
               state_ff <= ST_TA;
            end
            ST_TA: begin
               prod_ff <= p_ff * rtfd_pkg::rtfd_recip(k_ff);
               pnext_ff <= 29'(pu_prod >> 30);
               state_ff <= ST_TB;
            end
            ST_TB: begin
               acc_ff <= k_ff[0] ? (acc_ff - 32'(term)) : (acc_ff + 32'(term));
               p_ff <= pnext_ff;
               k_ff <= k_ff + 5'd1;
               state_ff <= (k_ff == 5'(rtfd_pkg::SERIES_TERMS - 1)) ? ST_ANG1 : ST_TA;
            end
            ST_ANG1: begin
               if (fold_ff) begin
                  phi_ff <= steep_ff ? (rtfd_pkg::Q30_HALF_MINUS_QUARTER + acc_x)
                                     : (rtfd_pkg::Q30_QUARTER_PI - acc_x);
               end else begin
                  phi_ff <= steep_ff ? (rtfd_pkg::Q30_HALF_PI - acc_x) : acc_x;
               end
               state_ff <= ST_ANG2;
            end
            ST_ANG2: begin
               // Bearing is pi/2 minus atan2, folded per quadrant into one add.
               if (origin_ff) begin
                  r_ff <= rtfd_pkg::Q30_HALF_PI;
               end else if (xneg_ff) begin
                  r_ff <= yneg_ff ? (rtfd_pkg::Q30_HALF_PLUS_PI - phi_ff)
                                  : (phi_ff - rtfd_pkg::Q30_HALF_PI);
               end else begin
                  r_ff <= yneg_ff ? (rtfd_pkg::Q30_HALF_PI + phi_ff)
                                  : (rtfd_pkg::Q30_HALF_PI - phi_ff);
               end
               state_ff <= ST_ANG3;
            end
            ST_ANG3: begin
               neg_ff <= r_ff[35];
               mag_ff <= r_ff[35] ? 33'(-r_ff) : 33'(r_ff);
               state_ff <= ST_M1;
            end
            ST_M1: begin
               n_ff <= 49'(lo_prod) + rtfd_pkg::Q30_PI_U;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               n_ff <= n_ff + (49'(hi_prod) << 17);
               state_ff <= ST_DEG;
            end
            ST_DEG: begin
               rh_ff <= n_ff[48:24] * rtfd_pkg::DEG_RECIP;
               rl_ff <= n_ff[23:0] * rtfd_pkg::DEG_RECIP;
               state_ff <= ST_DQ;
            end
            ST_DQ: begin
               // The reciprocal estimate is exact or one below the true quotient.
               qd_ff <= recip_sum[63:49];
               state_ff <= ST_DFIX;
            end
            ST_DFIX: begin
               if (deg_ge) begin
                  qd_ff <= qd_ff + 15'd1;
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_slot_ff <= slot_ff;
                  out_last_ff <= (slot_ff == 2'd2);
                  out_det_ff <= det_ff;
                  out_x_ff <= x_ff;
                  out_y_ff <= y_ff;
                  out_v_ff <= v_ff;
                  out_range_ff <= det_ff ? res_ff[15:0] : 16'd0;
                  out_bear_ff <= !det_ff ? 16'sd0 : (neg_ff ? -bear_mag : bear_mag);
                  slot_ff <= (slot_ff == 2'd2) ? 2'd0 : slot_ff + 2'd1;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.target_slot = out_slot_ff;
   assign rsp_chan.last = out_last_ff;
   assign rsp_chan.detected = out_det_ff;
   assign rsp_chan.pos_x = out_x_ff;
   assign rsp_chan.pos_y = out_y_ff;
   assign rsp_chan.velocity = out_v_ff;
   assign rsp_chan.range_mm = out_range_ff;
   assign rsp_chan.bearing_centideg = out_bear_ff;

   `RTFD_ASSERT_IMP(a_undetected_zero, clock, reset, rsp_chan.valid && !rsp_chan.detected,
      rsp_chan.range_mm == 16'd0 && rsp_chan.bearing_centideg == 16'sd0)
   `RTFD_ASSERT_IMP(a_last_slot, clock, reset, rsp_chan.valid,
      rsp_chan.last == (rsp_chan.target_slot == 2'd2))
   `RTFD_ASSERT_NEXT(a_pop_wraps, clock, reset, pop, slot_ff == 2'd0)

endmodule

// ----- sv/radar_target_frame_decoder_core.sv -----
// ----------------------------------------------------------------------------
// Radar target frame decoder
// Serial byte stream in, decoded radar targets out.
// ----------------------------------------------------------------------------
// req_chan takes one received byte per transfer. The hunter looks for the
// header AA FF 03 00, collects 24 data bytes and checks the tail 55 CC.
// A good frame goes into a two-frame queue; a bad tail drops it silently.
// rsp_chan gives three transfers per good frame, slots 0, 1, 2, with last
// set on slot 2. In the target unit each target passes in turn through
// the bit-serial divide, the 20-term atan series and the reciprocal
// conversion to hundredths of a degree; a frame's three targets are
// decoded one after another.
// Bytes are taken one per cycle at any time, except that the last byte of
// a frame waits while the queue holds two frames.
// A stalled rsp_chan holds its result; the target unit waits behind it and
// the hunter keeps taking bytes until the queue fills.
// Reset (synchronous, active high) returns the hunt to the first header
// byte and empties the queue and the output register.
// ----------------------------------------------------------------------------
module radar_target_frame_decoder_core (
   input  logic clock,
   input  logic reset,
   rtfd_req_if.sink req_chan,
   rtfd_rsp_if.source rsp_chan
);

   logic push, full, head_valid, pop;
   rtfd_pkg::rtfd_frame_type push_frame, head_frame;

   rtfd_front u_front (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .full(full),
      .push(push),
      .push_frame(push_frame)
   );

   rtfd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_frame(push_frame),
      .full(full),
      .head_valid(head_valid),
      .head_frame(head_frame),
      .pop(pop)
   );

   rtfd_back u_back (
      .clock(clock),
      .reset(reset),
      .head_valid(head_valid),
      .head_frame(head_frame),
      .pop(pop),
      .rsp_chan(rsp_chan)
   );

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Frame decoder testbench
// Feeds serial bytes into the decoder and checks every decoded target
// against a predictor of its own, under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint PI_Q = 64'hC90FDAA2;
   localparam longint HALF_PI_Q = 64'h6487ED51;
   localparam longint QUARTER_PI_Q = 64'h3243F6A9;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [1:0] target_slot;
      logic last;
      logic detected;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] velocity;
      logic [15:0] range_mm;
      logic signed [15:0] bearing_centideg;
   } target_type;

   typedef enum int {
      PH_NONE,
      PH_SEND,
      PH_RECV,
      PH_BOTH
   } idle_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rtfd_req_if req_chan ();
   rtfd_rsp_if rsp_chan ();

   radar_target_frame_decoder_core DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state
   int hunt_state;
   int stored_count;
   logic [7:0] frame_bytes [rtfd_pkg::FRAME_BYTES];
   target_type pending_targets[$];

   int mismatch_count;
   int cycle_count;
   idle_mode_type idle_mode;

   function automatic int decode_sm(logic [15:0] w);
      int mag;
      mag = int'(w[14:0]);
      return w[15] ? mag : -mag;
   endfunction

   function automatic int root_floor(longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 30;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return int'(res);
   endfunction

   function automatic longint arctan_series(longint unsigned u);
      longint unsigned u2, p;
      longint acc, term;
      u2 = (u * u) >> 30;
      p = u;
      acc = 0;
      for (int k = 0; k < 20; k++) begin
         term = longint'(p / longint'(2 * k + 1));
         acc = (k & 1) ? acc - term : acc + term;
         p = (p * u2) >> 30;
      end
      return acc;
   endfunction

   function automatic longint angle_of(int x, int y);
      longint unsigned ax, ay, a, b;
      longint th, phi;
      ax = x < 0 ? -x : x;
      ay = y < 0 ? -y : y;
      if (ax == 0 && ay == 0) return 0;
      a = ax < ay ? ax : ay;
      b = ax < ay ? ay : ax;
      if (5 * a > 2 * b) th = QUARTER_PI_Q - arctan_series(((b - a) << 30) / (b + a));
      else th = arctan_series((a << 30) / b);
      phi = (ay > ax) ? HALF_PI_Q - th : th;
      if (x >= 0) return (y >= 0) ? phi : -phi;
      return (y >= 0) ? PI_Q - phi : -(PI_Q - phi);
   endfunction

   function automatic int bearing_of(int x, int y);
      longint r;
      longint unsigned mag, q;
      r = HALF_PI_Q - angle_of(x, y);
      mag = r < 0 ? -r : r;
      q = (mag * 36000 + PI_Q) / (2 * PI_Q);
      return r < 0 ? -int'(q) : int'(q);
   endfunction

   // Advances the predictor by one byte and queues any decoded targets.
   task automatic predict_byte(logic [7:0] b);
      logic [15:0] rx, ry, rs, rp;
      int x, y;
      target_type t;
      case (hunt_state)
         1: hunt_state = (b == rtfd_pkg::HDR_BYTE1) ? 2 : 0;
         2: hunt_state = (b == rtfd_pkg::HDR_BYTE2) ? 3 : 0;
         3: begin
            if (b == rtfd_pkg::HDR_BYTE3) begin
               stored_count = 0;
               hunt_state = 4;
            end else begin
               hunt_state = 0;
            end
         end
         4: begin
            frame_bytes[stored_count] = b;
            stored_count++;
            if (stored_count == rtfd_pkg::FRAME_BYTES) begin
               hunt_state = 0;
               stored_count = 0;
               if (frame_bytes[24] == rtfd_pkg::TAIL_BYTE0 &&
                   frame_bytes[25] == rtfd_pkg::TAIL_BYTE1) begin
                  for (int s = 0; s < rtfd_pkg::NUM_TARGETS; s++) begin
                     rx = {frame_bytes[s*8+1], frame_bytes[s*8]};
                     ry = {frame_bytes[s*8+3], frame_bytes[s*8+2]};
                     rs = {frame_bytes[s*8+5], frame_bytes[s*8+4]};
                     rp = {frame_bytes[s*8+7], frame_bytes[s*8+6]};
                     x = decode_sm(rx);
                     y = decode_sm(ry);
                     t.target_slot = 2'(s);
                     t.last = (s == 2);
                     t.detected = (rx | ry | rs | rp) != 0;
                     t.pos_x = 16'(x);
                     t.pos_y = 16'(y);
                     t.velocity = 16'(decode_sm(rs));
                     t.range_mm = 0;
                     t.bearing_centideg = 0;
                     if (t.detected) begin
                        t.range_mm = 16'(root_floor(longint'(x) * x + longint'(y) * y));
                        t.bearing_centideg = 16'(bearing_of(x, y));
                     end
                     pending_targets.push_back(t);
                  end
               end
            end
         end
         default: hunt_state = (b == rtfd_pkg::HDR_BYTE0) ? 1 : 0;
      endcase
   endtask

   function automatic bit sender_idles();
      if (idle_mode == PH_SEND) return $urandom_range(99) < 48;
      if (idle_mode == PH_BOTH) return $urandom_range(99) < 35;
      return 0;
   endfunction

   function automatic bit receiver_stalls();
      if (idle_mode == PH_RECV) return $urandom_range(99) < 48;
      if (idle_mode == PH_BOTH) return $urandom_range(99) < 35;
      return 0;
   endfunction

   // Drives one byte and waits for its transfer; valid stays high into the
   // next byte unless the sender idles.
   task automatic send_byte(logic [7:0] b);
      if (sender_idles()) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
         while (sender_idles()) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.byte_in <= b;
      do @(posedge clock); while (!req_chan.ready);
      predict_byte(b);
      @(negedge clock);
   endtask

   function automatic logic [15:0] random_word();
      case ($urandom_range(5))
         0: return 16'h0000;
         1: return 16'h8000;
         2: return {$urandom_range(1) == 1, 15'h7FFF};
         3: return {$urandom_range(1) == 1, 15'($urandom_range(0, 15))};
         default: return 16'($urandom);
      endcase
   endfunction

   // Sends a header, 12 given words and a tail.
   task automatic send_frame(logic [15:0] words [12], logic [7:0] t0, logic [7:0] t1);
      send_byte(rtfd_pkg::HDR_BYTE0);
      send_byte(rtfd_pkg::HDR_BYTE1);
      send_byte(rtfd_pkg::HDR_BYTE2);
      send_byte(rtfd_pkg::HDR_BYTE3);
      for (int i = 0; i < 12; i++) begin
         send_byte(words[i][7:0]);
         send_byte(words[i][15:8]);
      end
      send_byte(t0);
      send_byte(t1);
   endtask

   task automatic send_random_frame(bit bad_tail);
      logic [15:0] w [12];
      int zero_tgt;
      zero_tgt = $urandom_range(5);
      for (int i = 0; i < 12; i++) w[i] = random_word();
      if (zero_tgt < 3)
         for (int i = 0; i < 4; i++) w[zero_tgt*4+i] = 16'h0000;
      if (bad_tail) begin
         if ($urandom_range(1)) send_frame(w, 8'($urandom), rtfd_pkg::TAIL_BYTE1);
         else send_frame(w, rtfd_pkg::TAIL_BYTE0, 8'($urandom));
      end else begin
         send_frame(w, rtfd_pkg::TAIL_BYTE0, rtfd_pkg::TAIL_BYTE1);
      end
   endtask

   task automatic wait_drained();
      while (pending_targets.size() != 0) @(negedge clock);
   endtask

   // Directed targets: {x, y, speed, pixel}; x/y edge cases with direction.
   logic [15:0] directed_words [8][4] = '{
      '{16'h0000, 16'h0000, 16'h0000, 16'h0000},  // nothing detected
      '{16'h8000, 16'h0000, 16'h0000, 16'h0000},  // positive zero still detected
      '{16'h0000, 16'h0000, 16'h0000, 16'h0001},  // origin target
      '{16'h0064, 16'h8000, 16'h8005, 16'h0000},  // on negative x axis
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},  // largest positive
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},  // largest negative
      '{16'h8064, 16'h0064, 16'h0001, 16'h0000},  // x positive, y negative
      '{16'h8000, 16'h83E8, 16'h8000, 16'h0000}   // straight ahead
   };
   // Expected (range, bearing) read directly off the definitions.
   int directed_range [8] = '{0, 0, 0, 100, 46339, 46339, 141, 1000};
   int directed_bearing [8] = '{0, 9000, 9000, -9000, 4500, 22500, 13500, 0};

   task automatic run_directed();
      logic [15:0] w [12];
      int idx;
      for (int f = 0; f < 3; f++) begin
         for (int s = 0; s < 3; s++) begin
            idx = (f * 3 + s) % 8;
            for (int k = 0; k < 4; k++) w[s*4+k] = directed_words[idx][k];
         end
         send_frame(w, rtfd_pkg::TAIL_BYTE0, rtfd_pkg::TAIL_BYTE1);
         // Check the expectations just queued against the typed-in values.
         for (int s = 0; s < 3; s++) begin
            idx = (f * 3 + s) % 8;
            if (pending_targets[pending_targets.size() - 3 + s].range_mm !=
                16'(directed_range[idx]) ||
                pending_targets[pending_targets.size() - 3 + s].bearing_centideg !=
                16'(directed_bearing[idx])) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("directed row %0d: predictor gives range %0d bearing %0d",
                           idx, pending_targets[pending_targets.size() - 3 + s].range_mm,
                           pending_targets[pending_targets.size() - 3 + s]
                              .bearing_centideg);
            end
         end
      end
      // Header recovery: a broken header, then a wrong byte that is AA.
      send_byte(rtfd_pkg::HDR_BYTE0);
      send_byte(rtfd_pkg::HDR_BYTE0);
      send_byte(rtfd_pkg::HDR_BYTE1);
      send_random_frame(1);
      send_random_frame(0);
   endtask

   // Result checker
   always @(posedge clock) begin
      target_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.target_slot = rsp_chan.target_slot;
         got.last = rsp_chan.last;
         got.detected = rsp_chan.detected;
         got.pos_x = rsp_chan.pos_x;
         got.pos_y = rsp_chan.pos_y;
         got.velocity = rsp_chan.velocity;
         got.range_mm = rsp_chan.range_mm;
         got.bearing_centideg = rsp_chan.bearing_centideg;
         if (pending_targets.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected target transfer %p", got);
         end else begin
            want = pending_targets.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("target mismatch: expected %p, actual %p", want, got);
            end
         end
      end
   end

   always @(negedge clock) rsp_chan.ready <= reset ? 1'b0 : !receiver_stalls();

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      hunt_state = 0;
      stored_count = 0;
      mismatch_count = 0;
      cycle_count = 0;
      idle_mode = PH_NONE;
      req_chan.valid = 1'b0;
      req_chan.byte_in = 8'h00;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();
      for (int p = 0; p < 4; p++) begin
         idle_mode = idle_mode_type'(p);
         for (int n = 0; n < 3; n++) begin
            case ($urandom_range(9))
               0: send_random_frame(1);
               1: repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
               2: begin
                  send_byte(rtfd_pkg::HDR_BYTE0);
                  send_byte(rtfd_pkg::HDR_BYTE1);
                  send_byte(8'($urandom));
               end
               default: send_random_frame(0);
            endcase
         end
      end
      req_chan.valid <= 1'b0;
      idle_mode = PH_BOTH;
      wait_drained();
      repeat (400) @(negedge clock);
      if (mismatch_count == 0 && pending_targets.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
